@@ hdl/smeu_pkg.sv @@
// Shared constants, codes and state type of the stack machine execute unit.
package smeu_pkg;

	localparam int DATA_DEPTH    = 1024;
	localparam int STACK_DEPTH   = 256;
	localparam int RETURN_DEPTH  = 64;
	localparam int PROGRAM_DEPTH = 4096;

	localparam int WORD_W  = 32;
	localparam int PC_W    = $clog2(PROGRAM_DEPTH);
	localparam int DATA_AW = $clog2(DATA_DEPTH);
	localparam int DU_W    = $clog2(DATA_DEPTH + 1);
	localparam int SP_AW   = $clog2(STACK_DEPTH);
	localparam int SC_W    = $clog2(STACK_DEPTH + 1);
	localparam int RS_AW   = $clog2(RETURN_DEPTH);
	localparam int RC_W    = $clog2(RETURN_DEPTH + 1);
	localparam int AX_W    = WORD_W + 2;

	localparam logic [WORD_W-1:0] FILL_WORD = WORD_W'(69);

	typedef enum logic [4:0] {
		OP_NOP         = 5'd0,
		OP_START       = 5'd1,
		OP_SUB         = 5'd2,
		OP_JUMP        = 5'd3,
		OP_JZ          = 5'd4,
		OP_JNZ         = 5'd5,
		OP_CALL        = 5'd6,
		OP_RET         = 5'd7,
		OP_PUSH_SCALAR = 5'd8,
		OP_PUSH_ARRAY  = 5'd9,
		OP_PUSH_IMM    = 5'd10,
		OP_POP         = 5'd11,
		OP_POP_SCALAR  = 5'd12,
		OP_POP_ARRAY   = 5'd13,
		OP_DUP         = 5'd14,
		OP_SWAP        = 5'd15,
		OP_ADD         = 5'd16,
		OP_NEG         = 5'd17,
		OP_MUL         = 5'd18,
		OP_DIV         = 5'd19,
		OP_PRINT_TOP   = 5'd20,
		OP_PRINT_STR   = 5'd21
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_EMPTY    = 2'd1,
		ERR_DIV0     = 2'd2,
		ERR_OVERFLOW = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		PK_NONE   = 2'd0,
		PK_VALUE  = 2'd1,
		PK_STRING = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_TOP,
		ST_RD_NXT,
		ST_ADDR,
		ST_EXEC,
		ST_SWAP,
		ST_FILL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

@@ hdl/smeu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module smeu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/smeu_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module smeu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [smeu_pkg::WORD_W-1:0] dividend,
	input  logic [smeu_pkg::WORD_W-1:0] divisor,
	output logic                        done,
	output logic [smeu_pkg::WORD_W-1:0] quotient
);

	localparam int W   = smeu_pkg::WORD_W;
	localparam int CW  = $clog2(W + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W:0]    rem_sh;
	logic [W:0]    diff;

	assign rem_sh   = {rem_q, quo_q[W-1]};
	assign diff     = rem_sh - {1'b0, den_q};
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = neg_q ? (W'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[W-1] ^ divisor[W-1];
			rem_q <= '0;
			quo_q <= dividend[W-1] ? (W'(0) - dividend) : dividend;
			den_q <= divisor[W-1] ? (W'(0) - divisor) : divisor;
		end else if (busy_q && (cnt_q != '0)) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

endmodule

@@ hdl/stack_machine_execute_unit.sv @@
// Top level: sequencer and datapath of the stack machine execute unit.
//
// Input channel (in_valid / in_stall) carries one decoded instruction word:
// op and its resolved operand. Output channel (out_valid / out_stall) returns
// one result word per instruction: next_pc, print_kind, print_value and
// error_code. One instruction is worked at a time; in_stall is high while it
// is in flight. The operand stack, return stack, frame markers and data words
// each live in a RAM with registered read, so an instruction reads top and
// next of stack in turn, then forms a data address and reads it, then writes
// back. Swap adds a state for its second stack write, frame allocation of n
// words fills one word per cycle, and divide runs the divider at one quotient
// bit a cycle. The next word is accepted only after the result is loaded.
// The result sits in an output register; the next instruction is accepted
// while it waits. A new result is held back while out_stall keeps the previous
// one in place.
// Reset clears pc, all counts and the frame registers; the RAMs need no clear
// since only entries below their counts are ever used.
module stack_machine_execute_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [4:0]                  op,
	input  logic signed [31:0]          operand,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [smeu_pkg::PC_W-1:0]   next_pc,
	output logic [1:0]                  print_kind,
	output logic signed [31:0]          print_value,
	output logic [1:0]                  error_code
);

	localparam int W       = smeu_pkg::WORD_W;
	localparam int PC_W    = smeu_pkg::PC_W;
	localparam int DATA_AW = smeu_pkg::DATA_AW;
	localparam int DU_W    = smeu_pkg::DU_W;
	localparam int SP_AW   = smeu_pkg::SP_AW;
	localparam int SC_W    = smeu_pkg::SC_W;
	localparam int RS_AW   = smeu_pkg::RS_AW;
	localparam int RC_W    = smeu_pkg::RC_W;
	localparam int AX_W    = smeu_pkg::AX_W;

	smeu_pkg::state_t state_q, state_n;

	// architectural state
	logic [PC_W-1:0] pc_q;
	logic [SC_W-1:0] sc_q;
	logic [RC_W-1:0] rsc_q;
	logic [RC_W-1:0] fmc_q;
	logic [DU_W-1:0] du_q, gw_q, lw_q, fb_q;

	// instruction in flight
	smeu_pkg::op_t   op_q;
	logic [W-1:0]    arg_q;
	logic [W-1:0]    top_q;
	logic [AX_W-1:0] addr_q;
	logic            ok_q;
	logic [DU_W-1:0] fill_n_q;

	// pending result and output register
	logic [PC_W-1:0]     res_pc_q;
	smeu_pkg::kind_t     res_kind_q;
	logic [W-1:0]        res_val_q;
	smeu_pkg::err_t      res_err_q;
	logic                out_valid_q;
	logic [PC_W-1:0]     out_pc_q;
	logic [1:0]          out_kind_q;
	logic [W-1:0]        out_val_q;
	logic [1:0]          out_err_q;
	logic                load_out;

	// RAM ports
	logic             st_we, st_re;
	logic [SP_AW-1:0] st_waddr, st_raddr;
	logic [W-1:0]     st_wdata, st_rdata;
	logic             dm_we, dm_re;
	logic [DATA_AW-1:0] dm_waddr, dm_raddr;
	logic [W-1:0]     dm_wdata, dm_rdata;
	logic             rs_we, rs_re;
	logic [RS_AW-1:0] rs_waddr, rs_raddr;
	logic [PC_W-1:0]  rs_wdata, rs_rdata;
	logic             mk_we, mk_re;
	logic [RS_AW-1:0] mk_waddr, mk_raddr;
	logic [DU_W-1:0]  mk_wdata, mk_rdata;

	// divider
	logic         div_start, div_done;
	logic [W-1:0] div_q;

	smeu_ram #(.WIDTH(W), .DEPTH(smeu_pkg::STACK_DEPTH)) u_stack_ram (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.re(st_re), .raddr(st_raddr), .rdata(st_rdata)
	);

	smeu_ram #(.WIDTH(W), .DEPTH(smeu_pkg::DATA_DEPTH)) u_data_ram (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.re(dm_re), .raddr(dm_raddr), .rdata(dm_rdata)
	);

	smeu_ram #(.WIDTH(PC_W), .DEPTH(smeu_pkg::RETURN_DEPTH)) u_ret_ram (
		.clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
		.re(rs_re), .raddr(rs_raddr), .rdata(rs_rdata)
	);

	smeu_ram #(.WIDTH(DU_W), .DEPTH(smeu_pkg::RETURN_DEPTH)) u_mark_ram (
		.clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
		.re(mk_re), .raddr(mk_raddr), .rdata(mk_rdata)
	);

	smeu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(top_q), .divisor(st_rdata),
		.done(div_done), .quotient(div_q)
	);

	// ---------------------------------------------------------------
	// address formation (ST_ADDR); next of stack is on st_rdata from here on
	// ---------------------------------------------------------------
	logic [W-1:0]      nxt;
	logic              nested;
	logic signed [AX_W-1:0] arg_x, gw_x, fb_x, t12, a_sel;
	logic              a_ok;

	assign nxt    = st_rdata;
	assign nested = ((DU_W+1)'(gw_q) + (DU_W+1)'(lw_q)) < (DU_W+1)'(du_q);
	assign arg_x  = {{(AX_W-W){arg_q[W-1]}}, arg_q};
	assign gw_x   = AX_W'(gw_q);
	assign fb_x   = AX_W'(fb_q);
	assign t12    = arg_x - gw_x;

	always_comb begin
		case (op_q)
			smeu_pkg::OP_PUSH_SCALAR: a_sel = nested ? (t12 + fb_x) : arg_x;
			smeu_pkg::OP_POP_SCALAR:
				a_sel = nested ? (t12[AX_W-1] ? arg_x : (t12 + fb_x)) : arg_x;
			default: a_sel = arg_x + {{(AX_W-W){top_q[W-1]}}, top_q};
		endcase
	end

	assign a_ok = !a_sel[AX_W-1] && (a_sel[AX_W-2:0] < (AX_W-1)'(du_q));

	// ---------------------------------------------------------------
	// execute (ST_EXEC)
	// ---------------------------------------------------------------
	logic [PC_W-1:0]  pc1, target;
	logic [W-1:0]     n32, room;
	logic             fits;
	logic [DU_W-1:0]  n_w, d_rel;
	logic [SP_AW-1:0] sp0, sp1, sp2;

	assign pc1    = pc_q + PC_W'(1);
	assign target = arg_q[PC_W-1:0];
	assign n32    = arg_q[W-1] ? '0 : arg_q;
	assign room   = W'(smeu_pkg::DATA_DEPTH) - W'(du_q);
	assign fits   = n32 <= room;
	assign n_w    = n32[DU_W-1:0];
	assign d_rel  = du_q - mk_rdata;
	assign sp0    = sc_q[SP_AW-1:0];
	assign sp1    = sp0 - SP_AW'(1);
	assign sp2    = sp0 - SP_AW'(2);

	smeu_pkg::err_t   ex_err;
	smeu_pkg::kind_t  ex_kind;
	smeu_pkg::state_t ex_goto;
	logic [PC_W-1:0]  ex_next;
	logic [W-1:0]     ex_val;
	logic             ex_st_we, ex_dm_we, ex_rs_we, ex_mk_we;
	logic [SP_AW-1:0] ex_st_addr;
	logic [W-1:0]     ex_st_data, ex_dm_data;
	logic [SC_W-1:0]  ex_sc;
	logic [RC_W-1:0]  ex_rsc, ex_fmc;
	logic [DU_W-1:0]  ex_du, ex_gw, ex_lw, ex_fb, ex_fill;
	logic             ex_div;

	always_comb begin
		ex_err     = smeu_pkg::ERR_NONE;
		ex_kind    = smeu_pkg::PK_NONE;
		ex_goto    = smeu_pkg::ST_DONE;
		ex_next    = pc1;
		ex_val     = '0;
		ex_st_we   = 1'b0;
		ex_dm_we   = 1'b0;
		ex_rs_we   = 1'b0;
		ex_mk_we   = 1'b0;
		ex_st_addr = sp0;
		ex_st_data = top_q;
		ex_dm_data = top_q;
		ex_sc      = sc_q;
		ex_rsc     = rsc_q;
		ex_fmc     = fmc_q;
		ex_du      = du_q;
		ex_gw      = gw_q;
		ex_lw      = lw_q;
		ex_fb      = fb_q;
		ex_fill    = '0;
		ex_div     = 1'b0;
		case (op_q)
			smeu_pkg::OP_START: begin
				if (!fits) begin
					ex_err = smeu_pkg::ERR_OVERFLOW;
				end else begin
					ex_gw   = n_w;
					ex_fill = n_w;
					ex_goto = smeu_pkg::ST_FILL;
				end
			end
			smeu_pkg::OP_SUB: begin
				if (fmc_q >= RC_W'(smeu_pkg::RETURN_DEPTH) || !fits) begin
					ex_err = smeu_pkg::ERR_OVERFLOW;
				end else begin
					ex_mk_we = 1'b1;
					ex_fmc   = fmc_q + RC_W'(1);
					if (((DU_W+1)'(gw_q) + (DU_W+1)'(n_w)) > (DU_W+1)'(du_q)) begin
						ex_lw = n_w;
					end else begin
						ex_fb = du_q;
					end
					ex_fill = n_w;
					ex_goto = smeu_pkg::ST_FILL;
				end
			end
			smeu_pkg::OP_JUMP: ex_next = target;
			smeu_pkg::OP_JZ, smeu_pkg::OP_JNZ: begin
				if (sc_q == '0) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else begin
					ex_sc = sc_q - SC_W'(1);
					if ((op_q == smeu_pkg::OP_JZ) == (top_q == '0)) begin
						ex_next = target;
					end
				end
			end
			smeu_pkg::OP_CALL: begin
				if (rsc_q >= RC_W'(smeu_pkg::RETURN_DEPTH)) begin
					ex_err = smeu_pkg::ERR_OVERFLOW;
				end else begin
					ex_rs_we = 1'b1;
					ex_rsc   = rsc_q + RC_W'(1);
					ex_next  = target;
				end
			end
			smeu_pkg::OP_RET: begin
				if (fmc_q == '0) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else begin
					if (du_q > mk_rdata) begin
						ex_du = mk_rdata;
						ex_fb = (fb_q > d_rel) ? (fb_q - d_rel) : '0;
					end
					ex_fmc = fmc_q - RC_W'(1);
					if (rsc_q != '0) begin
						ex_rsc  = rsc_q - RC_W'(1);
						ex_next = rs_rdata;
					end
				end
			end
			smeu_pkg::OP_PUSH_SCALAR: begin
				if (sc_q >= SC_W'(smeu_pkg::STACK_DEPTH) || !ok_q) begin
					ex_err = smeu_pkg::ERR_OVERFLOW;
				end else begin
					ex_st_we   = 1'b1;
					ex_st_data = dm_rdata;
					ex_sc      = sc_q + SC_W'(1);
				end
			end
			smeu_pkg::OP_PUSH_ARRAY: begin
				if (sc_q == '0) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else if (ok_q) begin
					ex_st_we   = 1'b1;
					ex_st_addr = sp1;
					ex_st_data = dm_rdata;
				end
			end
			smeu_pkg::OP_PUSH_IMM: begin
				if (sc_q >= SC_W'(smeu_pkg::STACK_DEPTH)) begin
					ex_err = smeu_pkg::ERR_OVERFLOW;
				end else begin
					ex_st_we   = 1'b1;
					ex_st_data = arg_q;
					ex_sc      = sc_q + SC_W'(1);
				end
			end
			smeu_pkg::OP_POP: begin
				if (sc_q == '0) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else begin
					ex_sc = sc_q - SC_W'(1);
				end
			end
			smeu_pkg::OP_POP_SCALAR: begin
				if (sc_q == '0) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else if (!ok_q) begin
					ex_err = smeu_pkg::ERR_OVERFLOW;
				end else begin
					ex_dm_we = 1'b1;
					ex_sc    = sc_q - SC_W'(1);
				end
			end
			smeu_pkg::OP_POP_ARRAY: begin
				if (sc_q < SC_W'(2)) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else if (ok_q) begin
					ex_dm_we   = 1'b1;
					ex_dm_data = nxt;
					ex_sc      = sc_q - SC_W'(2);
				end
			end
			smeu_pkg::OP_DUP: begin
				if (sc_q == '0) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else if (sc_q >= SC_W'(smeu_pkg::STACK_DEPTH)) begin
					ex_err = smeu_pkg::ERR_OVERFLOW;
				end else begin
					ex_st_we = 1'b1;
					ex_sc    = sc_q + SC_W'(1);
				end
			end
			smeu_pkg::OP_SWAP: begin
				if (sc_q < SC_W'(2)) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else begin
					ex_st_we   = 1'b1;
					ex_st_addr = sp1;
					ex_st_data = nxt;
					ex_goto    = smeu_pkg::ST_SWAP;
				end
			end
			smeu_pkg::OP_ADD, smeu_pkg::OP_MUL: begin
				if (sc_q < SC_W'(2)) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else begin
					ex_st_we   = 1'b1;
					ex_st_addr = sp2;
					ex_st_data = (op_q == smeu_pkg::OP_ADD) ? (top_q + nxt) : (top_q * nxt);
					ex_sc      = sc_q - SC_W'(1);
				end
			end
			smeu_pkg::OP_NEG: begin
				if (sc_q == '0) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else begin
					ex_st_we   = 1'b1;
					ex_st_addr = sp1;
					ex_st_data = W'(0) - top_q;
				end
			end
			smeu_pkg::OP_DIV: begin
				if (sc_q < SC_W'(2)) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else if (nxt == '0) begin
					ex_err = smeu_pkg::ERR_DIV0;
				end else begin
					ex_div  = 1'b1;
					ex_goto = smeu_pkg::ST_DIV;
				end
			end
			smeu_pkg::OP_PRINT_TOP: begin
				if (sc_q == '0) begin
					ex_err = smeu_pkg::ERR_EMPTY;
				end else begin
					ex_kind = smeu_pkg::PK_VALUE;
					ex_val  = top_q;
					ex_sc   = sc_q - SC_W'(1);
				end
			end
			smeu_pkg::OP_PRINT_STR: begin
				ex_kind = smeu_pkg::PK_STRING;
				ex_val  = arg_q;
			end
			default: ;
		endcase
		if (ex_err != smeu_pkg::ERR_NONE) begin
			ex_next = pc1;
			ex_kind = smeu_pkg::PK_NONE;
			ex_val  = '0;
		end
	end

	// ---------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------
	assign load_out = !out_valid_q || !out_stall;

	always_comb begin
		state_n = state_q;
		case (state_q)
			smeu_pkg::ST_IDLE:   if (in_valid) state_n = smeu_pkg::ST_RD_TOP;
			smeu_pkg::ST_RD_TOP: state_n = smeu_pkg::ST_RD_NXT;
			smeu_pkg::ST_RD_NXT: state_n = smeu_pkg::ST_ADDR;
			smeu_pkg::ST_ADDR:   state_n = smeu_pkg::ST_EXEC;
			smeu_pkg::ST_EXEC:   state_n = ex_goto;
			smeu_pkg::ST_SWAP:   state_n = smeu_pkg::ST_DONE;
			smeu_pkg::ST_FILL:   if (fill_n_q == '0) state_n = smeu_pkg::ST_DONE;
			smeu_pkg::ST_DIV:    if (div_done) state_n = smeu_pkg::ST_DONE;
			smeu_pkg::ST_DONE:   if (load_out) state_n = smeu_pkg::ST_IDLE;
			default:             state_n = smeu_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// outputs: handshake and RAM controls
	// ---------------------------------------------------------------
	always_comb begin
		in_stall  = (state_q != smeu_pkg::ST_IDLE);
		st_we     = 1'b0;
		st_waddr  = ex_st_addr;
		st_wdata  = ex_st_data;
		st_re     = 1'b0;
		st_raddr  = sp1;
		dm_we     = 1'b0;
		dm_waddr  = addr_q[DATA_AW-1:0];
		dm_wdata  = ex_dm_data;
		dm_re     = 1'b0;
		dm_raddr  = a_sel[DATA_AW-1:0];
		rs_we     = 1'b0;
		rs_waddr  = rsc_q[RS_AW-1:0];
		rs_wdata  = pc1;
		rs_re     = 1'b0;
		rs_raddr  = rsc_q[RS_AW-1:0] - RS_AW'(1);
		mk_we     = 1'b0;
		mk_waddr  = fmc_q[RS_AW-1:0];
		mk_wdata  = du_q;
		mk_re     = 1'b0;
		mk_raddr  = fmc_q[RS_AW-1:0] - RS_AW'(1);
		div_start = 1'b0;
		case (state_q)
			smeu_pkg::ST_RD_TOP: begin
				st_re = 1'b1;
				rs_re = 1'b1;
				mk_re = 1'b1;
			end
			smeu_pkg::ST_RD_NXT: begin
				st_re    = 1'b1;
				st_raddr = sp2;
			end
			smeu_pkg::ST_ADDR: dm_re = 1'b1;
			smeu_pkg::ST_EXEC: begin
				st_we     = ex_st_we;
				dm_we     = ex_dm_we;
				rs_we     = ex_rs_we;
				mk_we     = ex_mk_we;
				div_start = ex_div;
			end
			smeu_pkg::ST_SWAP: begin
				st_we    = 1'b1;
				st_waddr = sp2;
				st_wdata = top_q;
			end
			smeu_pkg::ST_FILL: begin
				dm_we    = (fill_n_q != '0);
				dm_waddr = du_q[DATA_AW-1:0];
				dm_wdata = smeu_pkg::FILL_WORD;
			end
			smeu_pkg::ST_DIV: begin
				st_we    = div_done;
				st_waddr = sp2;
				st_wdata = div_q;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign next_pc     = out_pc_q;
	assign print_kind  = out_kind_q;
	assign print_value = out_val_q;
	assign error_code  = out_err_q;

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smeu_pkg::ST_IDLE;
			pc_q        <= '0;
			sc_q        <= '0;
			rsc_q       <= '0;
			fmc_q       <= '0;
			du_q        <= '0;
			gw_q        <= '0;
			lw_q        <= '0;
			fb_q        <= '0;
			fill_n_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == smeu_pkg::ST_EXEC) begin
				pc_q     <= ex_next;
				sc_q     <= ex_sc;
				rsc_q    <= ex_rsc;
				fmc_q    <= ex_fmc;
				du_q     <= ex_du;
				gw_q     <= ex_gw;
				lw_q     <= ex_lw;
				fb_q     <= ex_fb;
				fill_n_q <= ex_fill;
			end
			// advance fill pointer one word a cycle
			if (state_q == smeu_pkg::ST_FILL && fill_n_q != '0) begin
				du_q     <= du_q + DU_W'(1);
				fill_n_q <= fill_n_q - DU_W'(1);
			end
			if (state_q == smeu_pkg::ST_DIV && div_done) begin
				sc_q <= sc_q - SC_W'(1);
			end
			if (state_q == smeu_pkg::ST_DONE && load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == smeu_pkg::ST_IDLE && in_valid) begin
			op_q  <= smeu_pkg::op_t'(op);
			arg_q <= operand;
		end
		if (state_q == smeu_pkg::ST_RD_NXT) begin
			top_q <= st_rdata;
		end
		if (state_q == smeu_pkg::ST_ADDR) begin
			addr_q <= a_sel;
			ok_q   <= a_ok;
		end
		if (state_q == smeu_pkg::ST_EXEC) begin
			res_pc_q   <= ex_next;
			res_kind_q <= ex_kind;
			res_val_q  <= ex_val;
			res_err_q  <= ex_err;
		end
		if (state_q == smeu_pkg::ST_DONE && load_out) begin
			out_pc_q   <= res_pc_q;
			out_kind_q <= res_kind_q;
			out_val_q  <= res_val_q;
			out_err_q  <= res_err_q;
		end
	end

endmodule

@@ verif/stack_machine_execute_unit_tb.sv @@
// Self-checking testbench of the stack machine execute unit.
`timescale 1ns / 100ps

module stack_machine_execute_unit_tb;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int FIRST_UNUSED_OP = 22;
	localparam int LAST_UNUSED_OP = 31;
	localparam logic [31:0] MIN_WORD = 32'h8000_0000;
	localparam logic [31:0] MAX_WORD = 32'h7fff_ffff;

	typedef struct packed {
		logic [smeu_pkg::PC_W-1:0] pc;
		logic [1:0]                kind;
		logic [31:0]               value;
		logic [1:0]                err;
	} outcome_t;

	class smeu_scoreboard;
		logic [smeu_pkg::PC_W-1:0] pc;
		logic [31:0]               ostack [smeu_pkg::STACK_DEPTH];
		int                        osc;
		logic [smeu_pkg::PC_W-1:0] rstack [smeu_pkg::RETURN_DEPTH];
		int                        rsc;
		logic [31:0]               dmem [smeu_pkg::DATA_DEPTH];
		int                        dused;
		int                        fmark [smeu_pkg::RETURN_DEPTH];
		int                        fmc;
		int                        gwords;
		int                        lwords;
		int                        fbase;
		outcome_t                  pending [$];
		int                        fails;

		function void clear();
			pc = 0; osc = 0; rsc = 0; dused = 0; fmc = 0;
			gwords = 0; lwords = 0; fbase = 0; fails = 0;
		endfunction

		function bit nested();
			return gwords + lwords < dused;
		endfunction

		function void fill(int n);
			for (int i = 0; i < n; i++) begin
				dmem[dused] = smeu_pkg::FILL_WORD;
				dused++;
			end
		endfunction

		// Work out the result of one accepted instruction word and queue it.
		function void note(logic [4:0] o, logic [31:0] raw);
			longint arg, a, t, d;
			logic [smeu_pkg::PC_W-1:0] nxt_pc, tgt;
			logic [31:0] top, nx;
			int n, sc, m, dd;
			outcome_t r;
			arg = longint'($signed(raw));
			nxt_pc = pc + 1'b1;
			tgt = raw[smeu_pkg::PC_W-1:0];
			sc = osc;
			top = sc > 0 ? ostack[sc-1] : '0;
			nx = sc > 1 ? ostack[sc-2] : '0;
			r = '0;
			r.err = smeu_pkg::ERR_NONE;
			n = arg < 0 ? 0 : (arg > smeu_pkg::DATA_DEPTH ? smeu_pkg::DATA_DEPTH + 1
				: int'(arg));
			case (o)
				smeu_pkg::OP_START: begin
					if (n > smeu_pkg::DATA_DEPTH - dused) r.err = smeu_pkg::ERR_OVERFLOW;
					else begin
						fill(n);
						gwords = n;
					end
				end
				smeu_pkg::OP_SUB: begin
					if (fmc >= smeu_pkg::RETURN_DEPTH || n > smeu_pkg::DATA_DEPTH - dused)
						r.err = smeu_pkg::ERR_OVERFLOW;
					else begin
						fmark[fmc] = dused;
						fmc++;
						if (gwords + n > dused) lwords = n;
						else fbase = dused;
						fill(n);
					end
				end
				smeu_pkg::OP_JUMP: nxt_pc = tgt;
				smeu_pkg::OP_JZ, smeu_pkg::OP_JNZ: begin
					if (sc < 1) r.err = smeu_pkg::ERR_EMPTY;
					else begin
						osc = sc - 1;
						if ((o == smeu_pkg::OP_JZ) == (top == 0)) nxt_pc = tgt;
					end
				end
				smeu_pkg::OP_CALL: begin
					if (rsc >= smeu_pkg::RETURN_DEPTH) r.err = smeu_pkg::ERR_OVERFLOW;
					else begin
						rstack[rsc] = nxt_pc;
						rsc++;
						nxt_pc = tgt;
					end
				end
				smeu_pkg::OP_RET: begin
					if (fmc == 0) r.err = smeu_pkg::ERR_EMPTY;
					else begin
						m = fmark[fmc-1];
						if (dused > m) begin
							dd = dused - m;
							dused = m;
							fbase = fbase > dd ? fbase - dd : 0;
						end
						fmc--;
						if (rsc > 0) begin
							rsc--;
							nxt_pc = rstack[rsc];
						end
					end
				end
				smeu_pkg::OP_PUSH_SCALAR: begin
					a = nested() ? arg - gwords + fbase : arg;
					if (sc >= smeu_pkg::STACK_DEPTH || a < 0 || a >= dused)
						r.err = smeu_pkg::ERR_OVERFLOW;
					else begin
						ostack[sc] = dmem[a];
						osc = sc + 1;
					end
				end
				smeu_pkg::OP_PUSH_ARRAY: begin
					if (sc < 1) r.err = smeu_pkg::ERR_EMPTY;
					else begin
						a = arg + longint'($signed(top));
						if (a >= 0 && a < dused) ostack[sc-1] = dmem[a];
					end
				end
				smeu_pkg::OP_PUSH_IMM: begin
					if (sc >= smeu_pkg::STACK_DEPTH) r.err = smeu_pkg::ERR_OVERFLOW;
					else begin
						ostack[sc] = raw;
						osc = sc + 1;
					end
				end
				smeu_pkg::OP_POP: begin
					if (sc < 1) r.err = smeu_pkg::ERR_EMPTY;
					else osc = sc - 1;
				end
				smeu_pkg::OP_POP_SCALAR: begin
					if (sc < 1) r.err = smeu_pkg::ERR_EMPTY;
					else begin
						a = arg;
						if (nested()) begin
							a = arg - gwords;
							a = a < 0 ? arg : a + fbase;
						end
						if (a < 0 || a >= dused) r.err = smeu_pkg::ERR_OVERFLOW;
						else begin
							dmem[a] = top;
							osc = sc - 1;
						end
					end
				end
				smeu_pkg::OP_POP_ARRAY: begin
					if (sc < 2) r.err = smeu_pkg::ERR_EMPTY;
					else begin
						a = arg + longint'($signed(top));
						if (a >= 0 && a < dused) begin
							dmem[a] = nx;
							osc = sc - 2;
						end
					end
				end
				smeu_pkg::OP_DUP: begin
					if (sc < 1) r.err = smeu_pkg::ERR_EMPTY;
					else if (sc >= smeu_pkg::STACK_DEPTH) r.err = smeu_pkg::ERR_OVERFLOW;
					else begin
						ostack[sc] = top;
						osc = sc + 1;
					end
				end
				smeu_pkg::OP_SWAP: begin
					if (sc < 2) r.err = smeu_pkg::ERR_EMPTY;
					else begin
						ostack[sc-1] = nx;
						ostack[sc-2] = top;
					end
				end
				smeu_pkg::OP_ADD, smeu_pkg::OP_MUL: begin
					if (sc < 2) r.err = smeu_pkg::ERR_EMPTY;
					else begin
						ostack[sc-2] = (o == smeu_pkg::OP_ADD) ? top + nx : top * nx;
						osc = sc - 1;
					end
				end
				smeu_pkg::OP_NEG: begin
					if (sc < 1) r.err = smeu_pkg::ERR_EMPTY;
					else ostack[sc-1] = -top;
				end
				smeu_pkg::OP_DIV: begin
					t = longint'($signed(top));
					d = longint'($signed(nx));
					if (sc < 2) r.err = smeu_pkg::ERR_EMPTY;
					else if (d == 0) r.err = smeu_pkg::ERR_DIV0;
					else begin
						ostack[sc-2] = 32'(t / d);
						osc = sc - 1;
					end
				end
				smeu_pkg::OP_PRINT_TOP: begin
					if (sc < 1) r.err = smeu_pkg::ERR_EMPTY;
					else begin
						r.kind = smeu_pkg::PK_VALUE;
						r.value = top;
						osc = sc - 1;
					end
				end
				smeu_pkg::OP_PRINT_STR: begin
					r.kind = smeu_pkg::PK_STRING;
					r.value = raw;
				end
				default: ;
			endcase
			if (r.err != smeu_pkg::ERR_NONE) begin
				nxt_pc = pc + 1'b1;
				r.kind = smeu_pkg::PK_NONE;
				r.value = '0;
			end
			pc = nxt_pc;
			r.pc = nxt_pc;
			pending.insert(pending.size(), r);
		endfunction

		function void check(outcome_t got);
			outcome_t want;
			if (pending.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result word: pc=%0d kind=%0d value=%h err=%0d",
						got.pc, got.kind, got.value, got.err);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				fails++;
				if (fails <= 10)
					$display("expected pc=%0d kind=%0d val=%h err=%0d got %0d %0d %h %0d",
						want.pc, want.kind, want.value, want.err,
						got.pc, got.kind, got.value, got.err);
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [4:0]                  op = '0;
	logic signed [31:0]          operand = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b1;
	logic [smeu_pkg::PC_W-1:0]   next_pc;
	logic [1:0]                  print_kind;
	logic signed [31:0]          print_value;
	logic [1:0]                  error_code;

	smeu_scoreboard sb = new();
	int cycles = 0;
	bit steady_send = 0;

	stack_machine_execute_unit uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note(op, operand);
			if (out_valid && !out_stall) sb.check({next_pc, print_kind, print_value, error_code});
		end
	end

	function int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_send || r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task send(input logic [4:0] o, input logic [31:0] v);
		int g;
		op <= o;
		operand <= v;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		g = draw_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return 32'($signed($urandom_range(0, 10)) - 5);
		if (r == 5) return MIN_WORD;
		if (r == 6) return MAX_WORD;
		return $urandom();
	endfunction

	function logic [31:0] pick_addr();
		if ($urandom_range(0, 9) == 0) return $urandom();
		return $urandom_range(0, sb.dused + 3);
	endfunction

	task send_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) send(smeu_pkg::OP_PUSH_IMM, pick_value());
		else if (r < 45)
			send(5'($urandom_range(smeu_pkg::OP_DUP, smeu_pkg::OP_DIV)), $urandom());
		else if (r < 52) send(smeu_pkg::OP_PUSH_SCALAR, pick_addr());
		else if (r < 59) send(smeu_pkg::OP_POP_SCALAR, pick_addr());
		else if (r < 65)
			send($urandom_range(0, 1) ? smeu_pkg::OP_PUSH_ARRAY : smeu_pkg::OP_POP_ARRAY,
				32'($signed($urandom_range(0, 8)) - 2));
		else if (r < 71) begin
			if ($urandom_range(0, 19) == 0)
				send(smeu_pkg::OP_SUB, $urandom_range(0, 1) ? $urandom() : 300);
			else send(smeu_pkg::OP_SUB, $urandom_range(0, 8));
		end
		else if (r < 77) send(smeu_pkg::OP_RET, $urandom());
		else if (r < 82) send(smeu_pkg::OP_CALL, $urandom());
		else if (r < 88)
			send(5'($urandom_range(smeu_pkg::OP_JUMP, smeu_pkg::OP_JNZ)), $urandom());
		else if (r < 93)
			send($urandom_range(0, 1) ? smeu_pkg::OP_PRINT_TOP : smeu_pkg::OP_PRINT_STR,
				$urandom());
		else if (r < 96) send(smeu_pkg::OP_START, $urandom_range(0, 16));
		else if (r < 98) send(5'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP)), $urandom());
		else send($urandom_range(0, 1) ? smeu_pkg::OP_NOP : smeu_pkg::OP_POP, $urandom());
	endtask

	// Receiver: random stalls, one long hold-off so the block backs up.
	initial begin
		int r;
		@(posedge clk iff arst_n);
		repeat (300) @(posedge clk);
		out_stall <= 1'b1;
		repeat (400) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		sb.clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-stack cases, arithmetic extremes, frames, calls and jumps.
		send(smeu_pkg::OP_PRINT_TOP, '0);
		send(smeu_pkg::OP_DIV, '0);
		send(smeu_pkg::OP_RET, '0);
		send(smeu_pkg::OP_START, 8);
		send(smeu_pkg::OP_PUSH_IMM, 32'hffff_ffff);
		send(smeu_pkg::OP_PUSH_IMM, MIN_WORD);
		send(smeu_pkg::OP_DIV, '0);
		send(smeu_pkg::OP_PUSH_IMM, '0);
		send(smeu_pkg::OP_SWAP, '0);
		send(smeu_pkg::OP_DIV, '0);
		send(smeu_pkg::OP_PUSH_SCALAR, 3);
		send(smeu_pkg::OP_POP_SCALAR, 100);
		send(smeu_pkg::OP_SUB, 4);
		send(smeu_pkg::OP_POP_SCALAR, 9);
		send(smeu_pkg::OP_CALL, 32'hffff_ffff);
		send(smeu_pkg::OP_RET, '0);
		send(smeu_pkg::OP_JUMP, MAX_WORD);
		send(smeu_pkg::OP_PUSH_IMM, MAX_WORD);
		send(smeu_pkg::OP_DUP, '0);
		send(smeu_pkg::OP_MUL, '0);
		send(smeu_pkg::OP_NEG, '0);
		send(smeu_pkg::OP_JZ, 5);
		send(smeu_pkg::OP_PRINT_STR, MIN_WORD);
		send(smeu_pkg::OP_PUSH_ARRAY, 1);
		send(smeu_pkg::OP_POP_ARRAY, 2000);
		send(smeu_pkg::OP_START, 32'hffff_fffb);
		send(smeu_pkg::OP_SUB, 2000);

		steady_send = 1;
		repeat (smeu_pkg::STACK_DEPTH + 4) send(smeu_pkg::OP_PUSH_IMM, $urandom());
		steady_send = 0;
		repeat (smeu_pkg::STACK_DEPTH + 4) send(smeu_pkg::OP_POP, '0);
		repeat (smeu_pkg::RETURN_DEPTH + 2) send(smeu_pkg::OP_CALL, $urandom());
		repeat (smeu_pkg::RETURN_DEPTH + 2) send(smeu_pkg::OP_SUB, $urandom_range(0, 1));
		repeat (smeu_pkg::RETURN_DEPTH + 2) send(smeu_pkg::OP_RET, '0);

		// Random programs, with stretches of back-to-back words.
		for (int i = 0; i < 400; i++) begin
			if (i % 100 == 0) steady_send = $urandom_range(0, 2) == 0;
			send_random();
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
